/* hdl/dgns_pkg.sv */
// Shared types and constants for the dynamic graph neighbour sum block.
package dgns_pkg;

  localparam int VAL_W  = 32;
  localparam int SUM_W  = 40;
  localparam int VTX_W  = 8;
  localparam int MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TOGGLE = 2'd0,
    MODE_SET    = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_TOG0  = 11'b000_0000_0100,
    ST_TOG1  = 11'b000_0000_1000,
    ST_TOG2  = 11'b000_0001_0000,
    ST_SET0  = 11'b000_0010_0000,
    ST_SET1  = 11'b000_0100_0000,
    ST_WALK  = 11'b000_1000_0000,
    ST_DRAIN = 11'b001_0000_0000,
    ST_QRY0  = 11'b010_0000_0000,
    ST_QRY1  = 11'b100_0000_0000
  } state_t;

endpackage

/* hdl/dgns_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module dgns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/dynamic_graph_neighbor_sum.sv */
// Top level of the dynamic graph neighbour sum block: sequencer and its three memories.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  mode, vertex_a, vertex_b, new_value
//   out      output     out_valid/out_ready  neighbor_sum
//
// A self-loop toggle skips the update of the second row. A set is bounded by the walk
// over the adjacency row, one vertex index per cycle, reading each neighbour's sum
// through the single read port of the cached sum memory. An ignored transaction goes
// straight back to idle, and a query of a vertex beyond the range skips the sum read.
// After reset a clearing pass zeroes every entry of all three memories, and no
// input transaction is accepted during it.
// A query result waits in the output register; the next input transaction is taken
// meanwhile, and only a further query stalls until that register has been emptied.
module dynamic_graph_neighbor_sum #(
  parameter int VERTICES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dgns_pkg::MODE_W-1:0]   mode,
  input  logic [dgns_pkg::VTX_W-1:0]    vertex_a,
  input  logic [dgns_pkg::VTX_W-1:0]    vertex_b,
  input  logic [dgns_pkg::VAL_W-1:0]    new_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dgns_pkg::SUM_W-1:0]    neighbor_sum
);

  import dgns_pkg::*;

  // Vertex index width, and a width wide enough to compare an input vertex with
  // the vertex count itself.
  localparam int VW = $clog2(VERTICES);
  localparam int EW = ((VW > VTX_W) ? VW : VTX_W) + 1;
  localparam logic [VW-1:0] LAST = VW'(VERTICES - 1);

  state_t state, state_next;

  // The accepted transaction.
  logic [VW-1:0]    item_a;
  logic [VW-1:0]    item_b;
  logic [VAL_W-1:0] item_val;
  logic             q_zero;

  // Walk and clearing counter, the shifted adjacency row and the pending sum update.
  logic [VW-1:0]       cnt;
  logic [VERTICES-1:0] row_sh;
  logic [SUM_W-1:0]    delta;
  logic                was_set;
  logic                pend;
  logic [VW-1:0]       pend_addr;

  logic                in_acc;
  logic                a_ok;
  logic                b_ok;
  logic                out_free;

  // Memory ports.
  logic                adj_we, adj_re;
  logic [VW-1:0]       adj_waddr, adj_raddr;
  logic [VERTICES-1:0] adj_wdata, adj_rd;
  logic                val_we, val_re;
  logic [VW-1:0]       val_waddr, val_raddr;
  logic [VAL_W-1:0]    val_wdata, val_rd;
  logic                sums_we, sums_re;
  logic [VW-1:0]       sums_waddr, sums_raddr;
  logic [SUM_W-1:0]    sums_wdata, sums_rd;

  logic [SUM_W-1:0]    val_ext;
  logic [SUM_W-1:0]    sum_adj;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign a_ok     = EW'(vertex_a) < EW'(VERTICES);
  assign b_ok     = EW'(vertex_b) < EW'(VERTICES);
  assign out_free = !out_valid || out_ready;

  // The value read from memory, sign-extended to the sum width. An edge that was
  // present has its far endpoint's value taken off; a new edge adds it.
  assign val_ext = {{(SUM_W - VAL_W){val_rd[VAL_W-1]}}, val_rd};
  assign sum_adj = was_set ? (sums_rd - val_ext) : (sums_rd + val_ext);

  always_comb begin
    state_next = state;
    adj_we     = 1'b0;
    adj_re     = 1'b0;
    adj_waddr  = item_a;
    adj_raddr  = item_a;
    adj_wdata  = adj_rd;
    val_we     = 1'b0;
    val_re     = 1'b0;
    val_waddr  = item_a;
    val_raddr  = item_a;
    val_wdata  = item_val;
    sums_we    = 1'b0;
    sums_re    = 1'b0;
    sums_waddr = item_a;
    sums_raddr = item_a;
    sums_wdata = sums_rd;
    unique case (state)
      ST_CLEAR: begin
        adj_we     = 1'b1;
        adj_waddr  = cnt;
        adj_wdata  = '0;
        val_we     = 1'b1;
        val_waddr  = cnt;
        val_wdata  = '0;
        sums_we    = 1'b1;
        sums_waddr = cnt;
        sums_wdata = '0;
        if (cnt == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (mode)
            MODE_TOGGLE: if (a_ok && b_ok) state_next = ST_TOG0;
            MODE_SET:    if (a_ok) state_next = ST_SET0;
            MODE_QUERY:  state_next = a_ok ? ST_QRY0 : ST_QRY1;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_TOG0: begin
        adj_re     = 1'b1;
        val_re     = 1'b1;
        val_raddr  = item_b;
        sums_re    = 1'b1;
        state_next = ST_TOG1;
      end
      ST_TOG1: begin
        adj_we     = 1'b1;
        adj_wdata  = adj_rd ^ (VERTICES'(1) << item_b);
        sums_we    = 1'b1;
        sums_wdata = adj_rd[item_b] ? (sums_rd - val_ext) : (sums_rd + val_ext);
        if (item_a != item_b) begin
          adj_re     = 1'b1;
          adj_raddr  = item_b;
          val_re     = 1'b1;
          sums_re    = 1'b1;
          sums_raddr = item_b;
          state_next = ST_TOG2;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TOG2: begin
        adj_we     = 1'b1;
        adj_waddr  = item_b;
        adj_wdata  = adj_rd ^ (VERTICES'(1) << item_a);
        sums_we    = 1'b1;
        sums_waddr = item_b;
        sums_wdata = sum_adj;
        state_next = ST_IDLE;
      end
      ST_SET0: begin
        adj_re     = 1'b1;
        val_re     = 1'b1;
        state_next = ST_SET1;
      end
      ST_SET1: begin
        val_we     = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        // Read the sum of neighbour cnt while the previous neighbour is written back.
        sums_re    = row_sh[0];
        sums_raddr = cnt;
        sums_we    = pend;
        sums_waddr = pend_addr;
        sums_wdata = sums_rd + delta;
        if (cnt == LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        sums_we    = pend;
        sums_waddr = pend_addr;
        sums_wdata = sums_rd + delta;
        state_next = ST_IDLE;
      end
      ST_QRY0: begin
        sums_re    = 1'b1;
        state_next = ST_QRY1;
      end
      ST_QRY1: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_WALK) && row_sh[0];
      if ((state == ST_CLEAR) || (state == ST_WALK)) begin
        cnt <= cnt + 1'b1;
      end else if (state == ST_SET1) begin
        cnt <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_a   <= VW'(EW'(vertex_a));
      item_b   <= VW'(EW'(vertex_b));
      item_val <= new_value;
      q_zero   <= !a_ok;
    end
    if (state == ST_TOG1) begin
      was_set <= adj_rd[item_b];
    end
    if (state == ST_SET1) begin
      row_sh <= adj_rd;
      delta  <= {{(SUM_W - VAL_W){item_val[VAL_W-1]}}, item_val} - val_ext;
    end else if (state == ST_WALK) begin
      row_sh <= row_sh >> 1;
    end
    pend_addr <= cnt;
  end

  // Output register: a query result waits here until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_QRY1) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_QRY1) && out_free) begin
      neighbor_sum <= q_zero ? '0 : sums_rd;
    end
  end

  dgns_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_we),
    .wr_addr (adj_waddr),
    .wr_data (adj_wdata),
    .rd_en   (adj_re),
    .rd_addr (adj_raddr),
    .rd_data (adj_rd)
  );

  dgns_ram #(.WIDTH(VAL_W), .DEPTH(VERTICES)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (val_wdata),
    .rd_en   (val_re),
    .rd_addr (val_raddr),
    .rd_data (val_rd)
  );

  dgns_ram #(.WIDTH(SUM_W), .DEPTH(VERTICES)) u_sums_ram (
    .clk     (clk),
    .wr_en   (sums_we),
    .wr_addr (sums_waddr),
    .wr_data (sums_wdata),
    .rd_en   (sums_re),
    .rd_addr (sums_raddr),
    .rd_data (sums_rd)
  );

`ifndef NO_ASSERTIONS
  // The sequencing never reads and writes the same sum entry in one cycle.
  a_sums_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (sums_we && sums_re) |-> (sums_waddr != sums_raddr))
    else $error("cached sum read and write collide");

  // Likewise for adjacency rows.
  a_adj_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (adj_we && adj_re) |-> (adj_waddr != adj_raddr))
    else $error("adjacency row read and write collide");

  // A finished query is held, not dropped, while the output register is full.
  a_query_held: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_QRY1) && out_valid && !out_ready) |=> (state == ST_QRY1))
    else $error("query result lost while output stalled");

  // A result only appears after a finished query.
  a_out_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_QRY1))
    else $error("result without a query");
`endif

endmodule
